// File: hdl/dsa_pkg.sv
// Shared types, codes and constants of the decimal string adder.
`default_nettype none
package dsa_pkg;

  localparam int unsigned CAP_W   = 9;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;

  typedef logic [1:0]        op_t;
  typedef logic [1:0]        status_t;
  typedef logic [CAP_W-1:0]  cap_t;
  typedef logic [CHAR_W-1:0] char_t;

  localparam op_t OP_FIRST  = 2'd0;
  localparam op_t OP_SECOND = 2'd1;
  localparam op_t OP_READ   = 2'd2;
  localparam op_t OP_NONE   = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_INVALID  = 2'd1;
  localparam status_t ST_TOO_LONG = 2'd2;
  localparam status_t ST_NO_SUM   = 2'd3;

  localparam cap_t  CAP_RESET  = 9'd258;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;
  localparam logic [4:0] RADIX = 5'd10;

endpackage
`default_nettype wire

// File: hdl/dsa_req_if.sv
// Request channel carrying operand characters and read requests.
`default_nettype none
interface dsa_req_if import dsa_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   op;
  char_t char_code;
  logic  last;

  modport source (output valid, op, char_code, last, input ready);
  modport sink (input valid, op, char_code, last, output ready);
endinterface
`default_nettype wire

// File: hdl/dsa_rsp_if.sv
// Response channel carrying completion status and sum digits.
`default_nettype none
interface dsa_rsp_if import dsa_pkg::*; ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [LEN_W-1:0]    result_length;
  char_t               digit_char;
  logic                final_digit;

  modport source (output valid, status, result_length, digit_char, final_digit, input ready);
  modport sink (input valid, status, result_length, digit_char, final_digit, output ready);
endinterface
`default_nettype wire

// File: hdl/dsa_cfg_if.sv
// Configuration write channel for the result capacity register.
`default_nettype none
interface dsa_cfg_if import dsa_pkg::*; ();
  logic valid;
  logic ready;
  cap_t result_capacity;

  modport source (output valid, result_capacity, input ready);
  modport sink (input valid, result_capacity, output ready);
endinterface
`default_nettype wire

// File: hdl/dsa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module dsa_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/decimal_string_adder.sv
// Top level of the decimal string adder: operand stores, carry walk and read-out.
//
// Usage: requests on req_i carry op, char_code and last. Characters of the
// first and second operand arrive most significant first, one per cycle
// while req_i.ready is high. The request with last set on the second
// operand starts the addition and yields one response with a status and
// the sum length. Read requests each yield one response with the next sum
// digit, most significant first. cfg_i writes the result capacity; it is
// always ready. A character load gives no response. A read's digit comes
// from the registered read port of the sum memory. During a completion
// the carry walk reads one digit pair from the operand memories per cycle
// and writes one sum digit. Responses sit in an output register, so a
// request can be taken while a response still waits; when the receiver
// stalls with a second response pending, req_i.ready stays low until the
// register drains. Reset clears the operand lengths and flags, the sum
// length and the sum-ready state and sets the capacity to 258. The digit
// memories are not cleared; only written entries ever reach a result.
`default_nettype none
module decimal_string_adder import dsa_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dsa_req_if.sink    req_i,
  dsa_rsp_if.source  rsp_o,
  dsa_cfg_if.sink    cfg_i
);

  localparam int unsigned AW   = $clog2(MAX_DIGITS);
  localparam int unsigned SAW  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned LW   = $clog2(MAX_DIGITS + 2);
  localparam int unsigned CMPW = (LW > CAP_W) ? LW : CAP_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_DIGITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state_q, state_d;
  cap_t               cap_q, cap_d;
  logic [LW-1:0]      len1_q, len1_d, len2_q, len2_d;
  logic               inv1_q, inv1_d, lz1_q, lz1_d, inv2_q, inv2_d, lz2_q, lz2_d;
  logic               closed1_q, closed1_d;
  logic [LW-1:0]      sum_len_q, sum_len_d, rp_q, rp_d;
  logic               sum_ready_q, sum_ready_d;
  logic [LW-1:0]      mx_q, mx_d, iss_q, iss_d;
  logic               carry_q, carry_d;
  logic               pv_q, pv_d, av_q, av_d, bv_q, bv_d;
  logic [SAW-1:0]     wk_q, wk_d;
  logic               rd_ok_q, rd_ok_d, rd_fin_q, rd_fin_d;
  status_t            res_status_q, res_status_d;
  logic [LEN_W-1:0]   res_len_q, res_len_d;
  logic               out_valid_q, out_valid_d;
  status_t            out_status_q, out_status_d;
  logic [LEN_W-1:0]   out_len_q, out_len_d;
  char_t              out_char_q, out_char_d;
  logic               out_final_q, out_final_d;

  logic               accept, out_free, sel2, is_dig;
  logic [LW-1:0]      cur_len, new_len, mx_c, cnt;
  logic               cur_inv, cur_lz, new_inv, new_lz;
  logic [DIGIT_W-1:0] dig;
  logic               op_we1, op_we2, op_re;
  logic [AW-1:0]      op_waddr, raddr1, raddr2;
  logic [DIGIT_W-1:0] rd1, rd2, add_a, add_b, sum_dig;
  logic [4:0]         add_s;
  logic               add_ge;
  logic               sum_we, sum_re;
  logic [SAW-1:0]     sum_waddr, sum_raddr;
  logic [DIGIT_W-1:0] sum_wdata, sum_rdata;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign sel2    = (req_i.op == OP_SECOND);
  assign cur_len = sel2 ? len2_q : (closed1_q ? '0 : len1_q);
  assign cur_inv = sel2 ? inv2_q : (!closed1_q && inv1_q);
  assign cur_lz  = sel2 ? lz2_q : (!closed1_q && lz1_q);
  assign is_dig  = (req_i.char_code >= CHAR_ZERO) && (req_i.char_code <= CHAR_NINE);
  assign dig     = is_dig ? DIGIT_W'(req_i.char_code - CHAR_ZERO) : '0;
  assign new_inv = cur_inv || !is_dig || (cur_len != '0 && dig != '0 && cur_lz);
  assign new_lz  = cur_lz || (is_dig && cur_len == '0 && dig == '0);
  assign new_len = (cur_len <= MAX_LEN) ? cur_len + 1'b1 : cur_len;
  assign op_waddr = AW'(cur_len);
  assign op_we1  = accept && req_i.op == OP_FIRST && cur_len < MAX_LEN;
  assign op_we2  = accept && sel2 && cur_len < MAX_LEN;

  assign mx_c   = (len1_q > len2_q) ? len1_q : len2_q;
  assign op_re  = (state_q == S_WALK) && (iss_q != mx_q);
  assign raddr1 = AW'(len1_q - 1'b1 - iss_q);
  assign raddr2 = AW'(len2_q - 1'b1 - iss_q);

  assign add_a   = av_q ? rd1 : '0;
  assign add_b   = bv_q ? rd2 : '0;
  assign add_s   = 5'(add_a) + 5'(add_b) + 5'(carry_q);
  assign add_ge  = add_s >= RADIX;
  assign sum_dig = add_ge ? DIGIT_W'(add_s - RADIX) : DIGIT_W'(add_s);
  assign cnt     = mx_q + LW'(carry_q);

  assign sum_we    = pv_q || (state_q == S_FLUSH && carry_q);
  assign sum_waddr = pv_q ? wk_q : SAW'(mx_q);
  assign sum_wdata = pv_q ? sum_dig : DIGIT_W'(1);
  assign sum_re    = accept && req_i.op == OP_READ;
  assign sum_raddr = SAW'(sum_len_q - 1'b1 - rp_q);

  dsa_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_first_ram (
    .clk_i, .we_i(op_we1), .waddr_i(op_waddr), .wdata_i(dig),
    .re_i(op_re), .raddr_i(raddr1), .rdata_o(rd1)
  );

  dsa_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_second_ram (
    .clk_i, .we_i(op_we2), .waddr_i(op_waddr), .wdata_i(dig),
    .re_i(op_re), .raddr_i(raddr2), .rdata_o(rd2)
  );

  dsa_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS + 1)) u_sum_ram (
    .clk_i, .we_i(sum_we), .waddr_i(sum_waddr), .wdata_i(sum_wdata),
    .re_i(sum_re), .raddr_i(sum_raddr), .rdata_o(sum_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cap_d        = cap_q;
    len1_d       = len1_q;
    len2_d       = len2_q;
    inv1_d       = inv1_q;
    lz1_d        = lz1_q;
    inv2_d       = inv2_q;
    lz2_d        = lz2_q;
    closed1_d    = closed1_q;
    sum_len_d    = sum_len_q;
    rp_d         = rp_q;
    sum_ready_d  = sum_ready_q;
    mx_d         = mx_q;
    iss_d        = iss_q;
    carry_d      = carry_q;
    pv_d         = 1'b0;
    av_d         = av_q;
    bv_d         = bv_q;
    wk_d         = wk_q;
    rd_ok_d      = rd_ok_q;
    rd_fin_d     = rd_fin_q;
    res_status_d = res_status_q;
    res_len_d    = res_len_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_len_d    = out_len_q;
    out_char_d   = out_char_q;
    out_final_d  = out_final_q;

    if (cfg_i.valid && cfg_i.ready) begin
      cap_d = cfg_i.result_capacity;
    end

    if (pv_q) begin
      carry_d = add_ge;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.op)
            OP_FIRST: begin
              len1_d    = new_len;
              inv1_d    = new_inv;
              lz1_d     = new_lz;
              closed1_d = req_i.last;
            end
            OP_SECOND: begin
              len2_d = new_len;
              inv2_d = new_inv;
              lz2_d  = new_lz;
              if (req_i.last) begin
                sum_ready_d = 1'b0;
                state_d     = S_CHECK;
              end
            end
            OP_READ: begin
              rd_ok_d  = sum_ready_q && (rp_q < sum_len_q);
              rd_fin_d = (rp_q + 1'b1 == sum_len_q);
              if (sum_ready_q && (rp_q < sum_len_q)) begin
                rp_d = rp_q + 1'b1;
              end
              state_d = S_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = rd_ok_q ? ST_OK : ST_NO_SUM;
          out_len_d    = '0;
          out_char_d   = rd_ok_q ? CHAR_ZERO + char_t'(sum_rdata) : '0;
          out_final_d  = rd_ok_q && rd_fin_q;
          state_d      = S_IDLE;
        end
      end
      S_CHECK: begin
        res_len_d = '0;
        if (len1_q == '0 || len2_q == '0 || inv1_q || inv2_q) begin
          res_status_d = ST_INVALID;
          state_d      = S_DONE;
        end else if (mx_c > MAX_LEN || CMPW'(mx_c) >= CMPW'(cap_q)) begin
          res_status_d = ST_TOO_LONG;
          state_d      = S_DONE;
        end else begin
          mx_d    = mx_c;
          iss_d   = '0;
          carry_d = 1'b0;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (iss_q != mx_q) begin
          pv_d  = 1'b1;
          av_d  = iss_q < len1_q;
          bv_d  = iss_q < len2_q;
          wk_d  = SAW'(iss_q);
          iss_d = iss_q + 1'b1;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (CMPW'(cnt) >= CMPW'(cap_q)) begin
          res_status_d = ST_TOO_LONG;
          res_len_d    = '0;
        end else begin
          res_status_d = ST_OK;
          res_len_d    = LEN_W'(cnt);
          sum_len_d    = cnt;
          rp_d         = '0;
          sum_ready_d  = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        len1_d    = '0;
        len2_d    = '0;
        inv1_d    = 1'b0;
        lz1_d     = 1'b0;
        inv2_d    = 1'b0;
        lz2_d     = 1'b0;
        closed1_d = 1'b0;
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_len_d    = res_len_q;
          out_char_d   = '0;
          out_final_d  = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      len1_q      <= '0;
      len2_q      <= '0;
      inv1_q      <= 1'b0;
      lz1_q       <= 1'b0;
      inv2_q      <= 1'b0;
      lz2_q       <= 1'b0;
      closed1_q   <= 1'b0;
      sum_len_q   <= '0;
      rp_q        <= '0;
      sum_ready_q <= 1'b0;
      mx_q        <= '0;
      iss_q       <= '0;
      carry_q     <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      len1_q      <= len1_d;
      len2_q      <= len2_d;
      inv1_q      <= inv1_d;
      lz1_q       <= lz1_d;
      inv2_q      <= inv2_d;
      lz2_q       <= lz2_d;
      closed1_q   <= closed1_d;
      sum_len_q   <= sum_len_d;
      rp_q        <= rp_d;
      sum_ready_q <= sum_ready_d;
      mx_q        <= mx_d;
      iss_q       <= iss_d;
      carry_q     <= carry_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    av_q         <= av_d;
    bv_q         <= bv_d;
    wk_q         <= wk_d;
    rd_ok_q      <= rd_ok_d;
    rd_fin_q     <= rd_fin_d;
    res_status_q <= res_status_d;
    res_len_q    <= res_len_d;
    out_status_q <= out_status_d;
    out_len_q    <= out_len_d;
    out_char_q   <= out_char_d;
    out_final_q  <= out_final_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.result_length = out_len_q;
  assign rsp_o.digit_char    = out_char_q;
  assign rsp_o.final_digit   = out_final_q;

`ifndef SYNTHESIS
  a_rp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= sum_len_q)
    else $error("read pointer ran past the sum length");

  a_sum_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_ready_q |-> sum_len_q != '0)
    else $error("sum marked ready with no digits");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (iss_q <= mx_q && mx_q <= MAX_LEN))
    else $error("carry walk index out of range");

  a_new_sum_rp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sum_ready_q) |-> rp_q == '0)
    else $error("new sum did not restart the read pointer");

  a_walk_no_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> !req_i.ready)
    else $error("request taken during the carry walk");
`endif

endmodule
`default_nettype wire
